[rtl/core/kfpi_pkg.sv]
// Shared types and constants for the keyframe position interpolator.
// No dependencies.
`timescale 1ns / 1ps
package kfpi_pkg;
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int FRAME_W = 16;
	localparam int POS_W   = 32;
	localparam int KEY_W   = FRAME_W + 2 * POS_W;

	typedef struct packed {
		logic [1:0]               kind;
		logic [FRAME_W-1:0]       frame;
		logic signed [POS_W-1:0]  key_x;
		logic signed [POS_W-1:0]  key_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic [1:0]               status;
	} out_beat_t;

	typedef struct packed {
		logic [FRAME_W-1:0]       frame;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
	} key_t;

	typedef struct packed {
		logic                     start;
		logic signed [POS_W:0]    diff_x;
		logic signed [POS_W:0]    diff_y;
		logic [FRAME_W-1:0]       num;
		logic [FRAME_W-1:0]       den;
	} div_req_t;
endpackage

[rtl/core/kfpi_ram.sv]
// Generic single-port synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module kfpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/core/kfpi_lerp.sv]
// Serial interpolation step: q = diff * num / den per axis, truncated toward zero.
// Depends on kfpi_pkg. One quotient bit per cycle for both axes.
`timescale 1ns / 1ps
module kfpi_lerp
	import kfpi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  div_req_t                 req,
	output logic                     done,
	output logic signed [POS_W-1:0]  q_x,
	output logic signed [POS_W-1:0]  q_y
);
	localparam int PW = POS_W + 1 + FRAME_W;
	localparam int CW = $clog2(PW + 1);

	logic [PW-1:0]   mag_x_q, mag_y_q, rem_x_q, rem_y_q;
	logic [FRAME_W-1:0] den_q, num_q;
	logic            neg_x_q, neg_y_q, busy_q, mul_q;
	logic [CW-1:0]   cnt_q;
	logic [PW:0]     tx, ty;
	logic [POS_W:0]  ax, ay;

	assign ax = req.diff_x[POS_W] ? (POS_W+1)'(0) - req.diff_x : req.diff_x;
	assign ay = req.diff_y[POS_W] ? (POS_W+1)'(0) - req.diff_y : req.diff_y;
	assign tx = {rem_x_q, mag_x_q[PW-1]};
	assign ty = {rem_y_q, mag_y_q[PW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mul_q  <= 1'b1;
				cnt_q  <= CW'(FRAME_W);
			end else if (busy_q && mul_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					mul_q <= 1'b0;
					cnt_q <= CW'(PW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// shift-add multiply, then restoring divide in place
	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_x_q <= '0;
			mag_y_q <= '0;
			rem_x_q <= PW'(ax);
			rem_y_q <= PW'(ay);
			num_q   <= req.num;
			den_q   <= req.den;
			neg_x_q <= req.diff_x[POS_W];
			neg_y_q <= req.diff_y[POS_W];
		end else if (busy_q && mul_q) begin
			mag_x_q <= (mag_x_q << 1) + (num_q[FRAME_W-1] ? rem_x_q : '0);
			mag_y_q <= (mag_y_q << 1) + (num_q[FRAME_W-1] ? rem_y_q : '0);
			num_q   <= num_q << 1;
			if (cnt_q == CW'(1)) begin
				rem_x_q <= '0;
				rem_y_q <= '0;
			end
		end else if (busy_q) begin
			if (tx >= (PW+1)'(den_q)) begin
				rem_x_q <= PW'(tx - (PW+1)'(den_q));
				mag_x_q <= {mag_x_q[PW-2:0], 1'b1};
			end else begin
				rem_x_q <= PW'(tx);
				mag_x_q <= {mag_x_q[PW-2:0], 1'b0};
			end
			if (ty >= (PW+1)'(den_q)) begin
				rem_y_q <= PW'(ty - (PW+1)'(den_q));
				mag_y_q <= {mag_y_q[PW-2:0], 1'b1};
			end else begin
				rem_y_q <= PW'(ty);
				mag_y_q <= {mag_y_q[PW-2:0], 1'b0};
			end
		end
	end

	assign q_x = neg_x_q ? POS_W'(0) - mag_x_q[POS_W-1:0] : mag_x_q[POS_W-1:0];
	assign q_y = neg_y_q ? POS_W'(0) - mag_y_q[POS_W-1:0] : mag_y_q[POS_W-1:0];
endmodule

[rtl/core/kfpi_ctrl.sv]
// Sequencer: scans, shifts and rewrites the key table in kfpi_ram; interpolates queries.
// Depends on kfpi_pkg, kfpi_ram, kfpi_lerp.
`timescale 1ns / 1ps
module kfpi_ctrl
	import kfpi_pkg::*;
#(
	parameter int MAX_KEYS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  cmd,
	input  logic      cmd_go,
	output logic      busy,
	output out_beat_t res,
	output logic      res_go
);
	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_SHRD  = 4'd3;
	localparam logic [3:0] S_SHWR  = 4'd4;
	localparam logic [3:0] S_PUT   = 4'd5;
	localparam logic [3:0] S_RDLO  = 4'd6;
	localparam logic [3:0] S_GETLO = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_RES   = 4'd9;

	logic [3:0]     state_q;
	in_beat_t       cmd_q;
	logic [CW-1:0]  count_q, idx_q, pos_q, idx_dn;
	logic [AW-1:0]  addr;
	logic           we;
	key_t           wkey, rkey, hi_q, lo_q;
	out_beat_t      res_q;
	div_req_t       dreq;
	logic           ddone;
	logic signed [POS_W-1:0] qx, qy;

	kfpi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wkey), .rdata(rkey)
	);

	kfpi_lerp u_lerp (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .q_x(qx), .q_y(qy)
	);

	assign busy   = state_q != S_IDLE;
	assign res    = res_q;
	assign res_go = state_q == S_RES;
	assign idx_dn = idx_q - 1'b1;

	always_comb begin
		addr = idx_q[AW-1:0];
		we   = 1'b0;
		wkey = rkey;
		dreq = '0;
		case (state_q)
			S_SHRD: begin
				addr = idx_dn[AW-1:0];
			end
			S_SHWR: begin
				we = 1'b1;
			end
			S_PUT: begin
				we   = 1'b1;
				wkey = '{frame: cmd_q.frame, x: cmd_q.key_x, y: cmd_q.key_y};
			end
			S_GETLO: begin
				dreq.start  = pos_q != count_q;
				dreq.diff_x = (POS_W+1)'(hi_q.x) - (POS_W+1)'(rkey.x);
				dreq.diff_y = (POS_W+1)'(hi_q.y) - (POS_W+1)'(rkey.y);
				dreq.num    = cmd_q.frame - rkey.frame;
				dreq.den    = hi_q.frame - rkey.frame;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_go) begin
						idx_q <= '0;
						if (cmd.kind == KIND_CLEAR) begin
							count_q <= '0;
							state_q <= S_RES;
						end else if (cmd.kind == KIND_WRITE || cmd.kind == KIND_QUERY) begin
							state_q <= count_q == '0 ? S_CHK : S_SCAN;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_SCAN: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					// rkey holds entry idx_q when idx_q < count_q
					if (idx_q < count_q && rkey.frame < cmd_q.frame) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN;
					end else if (cmd_q.kind == KIND_WRITE) begin
						if (idx_q < count_q && rkey.frame == cmd_q.frame) begin
							state_q <= S_PUT;
						end else if (count_q == CW'(MAX_KEYS)) begin
							state_q <= S_RES;
						end else begin
							count_q <= count_q + 1'b1;
							idx_q   <= count_q;
							state_q <= idx_q == count_q ? S_PUT : S_SHRD;
						end
					end else if (count_q == '0 || idx_q == '0
						|| (idx_q < count_q && rkey.frame == cmd_q.frame)) begin
						state_q <= S_RES;
					end else if (idx_q == count_q) begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_RDLO;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_RDLO;
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					idx_q   <= idx_dn;
					state_q <= S_SHRD;
					if (idx_dn == pos_q) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					state_q <= S_RES;
				end
				S_RDLO: begin
					state_q <= S_GETLO;
				end
				S_GETLO: begin
					state_q <= dreq.start ? S_DIV : S_RES;
				end
				S_DIV: begin
					if (ddone) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// shift moves entries [pos, count-1] up one: read j-1 then write j
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd;
				res_q <= '0;
			end
			S_CHK: begin
				hi_q  <= rkey;
				pos_q <= idx_q;
				if (cmd_q.kind == KIND_WRITE) begin
					if (!(idx_q < count_q && rkey.frame < cmd_q.frame)
						&& !(idx_q < count_q && rkey.frame == cmd_q.frame)
						&& count_q == CW'(MAX_KEYS)) begin
						res_q.status <= ST_FULL;
					end
				end else if (!(idx_q < count_q && rkey.frame < cmd_q.frame)) begin
					if (count_q == '0) begin
						res_q.status <= ST_EMPTY;
					end else if (idx_q == '0
						|| (idx_q < count_q && rkey.frame == cmd_q.frame)) begin
						res_q.pos_x <= rkey.x;
						res_q.pos_y <= rkey.y;
					end
				end
			end
			S_GETLO: begin
				lo_q <= rkey;
				if (!dreq.start) begin
					res_q.pos_x <= rkey.x;
					res_q.pos_y <= rkey.y;
				end
			end
			S_DIV: begin
				if (ddone) begin
					res_q.pos_x <= lo_q.x + qx;
					res_q.pos_y <= lo_q.y + qy;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

[rtl/core/keyframe_position_interpolator.sv]
// Top level of the keyframe position interpolator: handshakes and output register.
// Depends on kfpi_pkg, kfpi_ctrl.
//
//  channel | dir | signals                    | payload
//  in      | in  | in_valid / in_ready        | in_beat_t (kind, frame, key_x, key_y)
//  out     | out | out_valid / out_ready      | out_beat_t (pos_x, pos_y, status)
//
// One item at a time, bound by the single table RAM port: a scan reads each key below
// the target, an insert reads and writes each shifted key, a query between keys adds
// the serial multiply-divide. A clear or unused kind goes straight to the result.
// Reset empties the table (key count zero); RAM contents are left as they are.
// in_ready stays low while a result beat waits, so out_ready low also stalls the input.
`timescale 1ns / 1ps
module keyframe_position_interpolator
	import kfpi_pkg::*;
#(
	parameter int MAX_KEYS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);
	logic      busy, res_go;
	out_beat_t res;

	assign in_ready = !busy && !out_valid;

	kfpi_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cmd(in_data), .cmd_go(in_valid && in_ready),
		.busy(busy), .res(res), .res_go(res_go)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_go) begin
			out_data <= res;
		end
	end
endmodule

[bench/keyframe_position_interpolator_tb.sv]
// Testbench for keyframe_position_interpolator: directed table, then random beats,
// every result checked against its row's value or an in-bench keyframe predictor.
// Depends on kfpi_pkg and the keyframe_position_interpolator RTL.
`timescale 1ns / 1ps
module keyframe_position_interpolator_tb;
	import kfpi_pkg::*;

	localparam int NKEYS = 64;
	localparam int NRAND = 460;

	typedef struct {
		in_beat_t  stim;
		logic      known;
		out_beat_t res;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;

	logic [FRAME_W-1:0]      key_frames[NKEYS];
	logic signed [POS_W-1:0] key_xs[NKEYS];
	logic signed [POS_W-1:0] key_ys[NKEYS];
	int                      key_num = 0;

	out_beat_t pending_pos[$];
	int        errors = 0;
	int        stall_left = 0;
	logic      calm = 1'b0;
	logic      stim_done = 1'b0;
	row_t      rows[$];

	keyframe_position_interpolator #(.MAX_KEYS(NKEYS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [POS_W-1:0] lerp(logic signed [POS_W-1:0] lo,
			logic signed [POS_W-1:0] hi, longint num, longint den);
		longint diff;
		diff = longint'(hi) - longint'(lo);
		return POS_W'(longint'(lo) + (diff * num) / den);
	endfunction

	function automatic out_beat_t keytable_step(in_beat_t b);
		out_beat_t r;
		int i;
		r = '0;
		i = 0;
		while (i < key_num && key_frames[i] < b.frame) i++;
		case (b.kind)
			KIND_WRITE: begin
				if (i < key_num && key_frames[i] == b.frame) begin
					key_xs[i] = b.key_x;
					key_ys[i] = b.key_y;
				end else if (key_num >= NKEYS) begin
					r.status = ST_FULL;
				end else begin
					for (int j = key_num; j > i; j--) begin
						key_frames[j] = key_frames[j-1];
						key_xs[j] = key_xs[j-1];
						key_ys[j] = key_ys[j-1];
					end
					key_frames[i] = b.frame;
					key_xs[i] = b.key_x;
					key_ys[i] = b.key_y;
					key_num++;
				end
			end
			KIND_CLEAR: key_num = 0;
			KIND_QUERY: begin
				if (key_num == 0) begin
					r.status = ST_EMPTY;
				end else if (i == 0 || (i < key_num && key_frames[i] == b.frame)) begin
					r.pos_x = key_xs[i];
					r.pos_y = key_ys[i];
				end else if (i >= key_num) begin
					r.pos_x = key_xs[key_num-1];
					r.pos_y = key_ys[key_num-1];
				end else begin
					r.pos_x = lerp(key_xs[i-1], key_xs[i], b.frame - key_frames[i-1],
						key_frames[i] - key_frames[i-1]);
					r.pos_y = lerp(key_ys[i-1], key_ys[i], b.frame - key_frames[i-1],
						key_frames[i] - key_frames[i-1]);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_beat_t mk(logic [1:0] k, logic [15:0] f, logic [31:0] x,
			logic [31:0] y);
		in_beat_t b;
		b.kind = k;
		b.frame = f;
		b.key_x = x;
		b.key_y = y;
		return b;
	endfunction

	function automatic out_beat_t res(logic [31:0] x, logic [31:0] y, logic [1:0] s);
		out_beat_t r;
		r.pos_x = x;
		r.pos_y = y;
		r.status = s;
		return r;
	endfunction

	task automatic add_row(in_beat_t b, logic known, out_beat_t r);
		row_t w;
		w.stim = b;
		w.known = known;
		w.res = r;
		rows = {rows, w};
	endtask

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		int sel;
		sel = $urandom_range(0, 99);
		b.key_x = $urandom;
		b.key_y = $urandom;
		if ($urandom_range(0, 3) == 0)
			b.key_x = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		b.frame = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300));
		if (sel < 45) b.kind = KIND_WRITE;
		else if (sel < 92) b.kind = KIND_QUERY;
		else if (sel < 97) b.kind = KIND_CLEAR;
		else b.kind = 2'd3;
		return b;
	endfunction

	// valid stays high across back-to-back beats and drops only for an idle burst
	task automatic send(in_beat_t b);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		pending_pos = {pending_pos, keytable_step(b)};
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		add_row(mk(KIND_QUERY, 16'd100, 0, 0), 1'b1, res(0, 0, ST_EMPTY));
		add_row(mk(2'd3, 16'hffff, 32'hffffffff, 32'hffffffff), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_WRITE, 16'd10, 32'h7fffffff, 32'h80000000), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_QUERY, 16'd0, 0, 0), 1'b1, res(32'h7fffffff, 32'h80000000, ST_OK));
		add_row(mk(KIND_QUERY, 16'hffff, 0, 0), 1'b1, res(32'h7fffffff, 32'h80000000, ST_OK));
		add_row(mk(KIND_WRITE, 16'd20, 32'h80000000, 32'h7fffffff), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_QUERY, 16'd15, 0, 0), 1'b0, '0);
		add_row(mk(KIND_QUERY, 16'd11, 0, 0), 1'b0, '0);
		add_row(mk(KIND_QUERY, 16'd19, 0, 0), 1'b0, '0);
		add_row(mk(KIND_QUERY, 16'd20, 0, 0), 1'b1, res(32'h80000000, 32'h7fffffff, ST_OK));
		add_row(mk(KIND_WRITE, 16'd0, 32'h00010000, 32'hffff0000), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_WRITE, 16'hffff, 32'h12345678, 32'hedcba987), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_QUERY, 16'd5, 0, 0), 1'b0, '0);
		add_row(mk(KIND_QUERY, 16'h8000, 0, 0), 1'b0, '0);
		add_row(mk(KIND_WRITE, 16'd10, 32'h0, 32'h0), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_QUERY, 16'd10, 0, 0), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_CLEAR, 16'd0, 0, 0), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_QUERY, 16'd10, 0, 0), 1'b1, res(0, 0, ST_EMPTY));
		for (int k = 0; k < NKEYS; k++)
			add_row(mk(KIND_WRITE, 16'(k * 1000), $urandom, $urandom), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_WRITE, 16'd1, 32'h1, 32'h1), 1'b1, res(0, 0, ST_FULL));
		add_row(mk(KIND_WRITE, 16'd2000, 32'h5, 32'h6), 1'b1, res(0, 0, ST_OK));
		add_row(mk(KIND_QUERY, 16'd2000, 0, 0), 1'b1, res(32'h5, 32'h6, ST_OK));
		add_row(mk(KIND_QUERY, 16'd62999, 0, 0), 1'b0, '0);
		add_row(mk(KIND_QUERY, 16'd65535, 0, 0), 1'b0, '0);
		add_row(mk(KIND_CLEAR, 16'd0, 0, 0), 1'b1, res(0, 0, ST_OK));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[n]) begin
			if (rows[n].known) begin
				send(rows[n].stim);
				pending_pos[$] = rows[n].res;
			end else begin
				send(rows[n].stim);
			end
		end
		for (int n = 0; n < NRAND; n++) begin
			if (n == NRAND - 80) calm <= 1'b1;
			send(rand_beat());
		end
		in_valid <= 1'b0;
		stim_done <= 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_pos.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					if (out_data.pos_x !== pending_pos[0].pos_x)
						$display("%0t: pos_x expected %h actual %h", $time,
							pending_pos[0].pos_x, out_data.pos_x);
					if (out_data.pos_y !== pending_pos[0].pos_y)
						$display("%0t: pos_y expected %h actual %h", $time,
							pending_pos[0].pos_y, out_data.pos_y);
					if (out_data.status !== pending_pos[0].status)
						$display("%0t: status expected %0d actual %0d", $time,
							pending_pos[0].status, out_data.status);
					if (out_data !== pending_pos[0]) errors++;
					void'(pending_pos.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (stim_done);
		while (pending_pos.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_pos.size() == 0) begin
			$display("keyframe_position_interpolator_tb OK");
		end else begin
			$display("keyframe_position_interpolator_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("keyframe_position_interpolator_tb NOT OK");
		$finish;
	end
endmodule
